// ----- hw/rtl/text_console_writer_unit_defines.svh -----
// assertion macros for the text console writer
// sampled on clk, disabled while rst is high; no other dependencies
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define TCW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TCW_ASSERT(label, cond, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// shared types and constants for the text console writer
// no dependencies
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  // request kinds carried on tuser
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // one screen cell, attribute in the high byte
  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_COPY  = 6'b001000,
    S_FILL  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_cell_ram.sv -----
// screen cell store: one write port, one read port with registered read data
// depends on tcw_pkg for the cell type
`default_nettype none

module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire cell_t                     wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output cell_t                          rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_writer_unit.sv -----
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (character in the low byte,
// attribute in the high byte) with a cursor. A put beat (tuser = 0) writes char_code at the
// cursor with the configured attribute and advances the cursor, or moves to the next row
// for a newline (code 10); running past the last row scrolls the screen up one row and fills
// the bottom row with spaces. A read beat (tuser = 1) returns one cell and the cursor; cells
// outside the screen read as zero. Every request gives exactly one result beat. A read or a
// put without scroll goes from accept through the execute and result states; a scroll adds
// a copy pass over (ROWS-1)*COLUMNS cells and a fill pass over the bottom row, since the screen
// store moves one cell per cycle through its single read and single write port. After reset
// the store is cleared one cell per cycle over all ROWS*COLUMNS cells before the first request
// is taken; attribute writes are taken at any time.
// depends on tcw_pkg, tcw_cell_ram and text_console_writer_unit_defines.svh
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // attribute register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic        s_axis_tuser,   // req_type[0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // cell_char[7:0], cell_attr[15:8],
                                           // cursor_row[20:16], cursor_col[27:21], scrolled[28]
);

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [ATTR_W-1:0] text_attr;

  logic              req_q;
  logic [7:0]        code_q;
  logic [4:0]        rrow_q;
  logic [6:0]        rcol_q;
  logic              rd_hit;
  logic              scr_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_t             ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  cell_t             ram_rdata;

  logic              s_fire;
  logic              rd_in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [CNT_W-1:0]  cnt_src;
  logic [CNT_W-1:0]  cnt_dst;
  logic [CNT_W-1:0]  cnt_fill;

  logic              is_nl;
  logic              wrap;
  logic              row_step;
  logic              row_over;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  cell_t             res_cell;

  logic              cursor_ok;
  logic              scroll_row_ok;
  logic              copy_last;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_attr <= cfg_data;
    end
  end

  assign rd_in_range = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLUMNS));
  assign rd_addr  = ADDR_W'(ADDR_W'(rrow_q) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_q));
  assign cur_addr = ADDR_W'(ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col));

  // scroll walk: read one row below, write the cell read on the previous cycle one row up
  assign cnt_src  = CNT_W'(cnt + CNT_W'(COLUMNS));
  assign cnt_dst  = CNT_W'(cnt - 1'b1);
  assign cnt_fill = CNT_W'(cnt + CNT_W'(COPY_N));

  // cursor advance for a put
  assign is_nl    = (code_q == NEWLINE_CODE);
  assign col_inc  = {1'b0, cursor_col} + 1'b1;
  assign wrap     = !is_nl && (col_inc == (COL_W+1)'(COLUMNS));
  assign row_step = is_nl || wrap;
  assign row_inc  = {1'b0, cursor_row} + 1'b1;
  assign row_over = row_step && (row_inc == (ROW_W+1)'(ROWS));
  assign col_next = row_step ? '0 : col_inc[COL_W-1:0];
  assign row_next = row_over ? ROW_W'(ROWS - 1)
                             : (row_step ? row_inc[ROW_W-1:0] : cursor_row);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
      end
      S_EXEC: begin
        if (req_q == REQ_READ) begin
          ram_re = rd_in_range;
        end else if (!is_nl) begin
          ram_we    = 1'b1;
          ram_wdata = '{attr: text_attr, chr: code_q};
        end
      end
      S_COPY: begin
        ram_re    = (32'(cnt) < 32'(COPY_N));
        ram_raddr = cnt_src[ADDR_W-1:0];
        ram_we    = (cnt != '0);
        ram_waddr = cnt_dst[ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_fill[ADDR_W-1:0];
        ram_wdata = '{attr: text_attr, chr: SPACE_CODE};
      end
      default: begin
      end
    endcase
  end

  tcw_cell_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_cell = rd_hit ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      cursor_row    <= '0;
      cursor_col    <= '0;
      m_axis_tvalid <= 1'b0;
      rd_hit        <= 1'b0;
      scr_q         <= 1'b0;
    end else begin
      // the result state drives tvalid itself
      if (m_axis_tvalid && m_axis_tready && state != S_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (32'(cnt) == 32'(DEPTH - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= CNT_W'(cnt + 1'b1);
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_q == REQ_READ) begin
            rd_hit <= rd_in_range;
            scr_q  <= 1'b0;
            state  <= S_RESP;
          end else begin
            rd_hit     <= 1'b0;
            scr_q      <= row_over;
            cursor_row <= row_next;
            cursor_col <= col_next;
            cnt        <= '0;
            state      <= row_over ? S_COPY : S_RESP;
          end
        end
        S_COPY: begin
          if (32'(cnt) == 32'(COPY_N)) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= CNT_W'(cnt + 1'b1);
          end
        end
        S_FILL: begin
          if (32'(cnt) == 32'(COLUMNS - 1)) begin
            cnt   <= '0;
            state <= S_RESP;
          end else begin
            cnt <= CNT_W'(cnt + 1'b1);
          end
        end
        S_RESP: begin
          // wait for the output register to free up
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_q  <= s_axis_tuser;
      code_q <= s_axis_tdata[7:0];
      rrow_q <= s_axis_tdata[12:8];
      rcol_q <= s_axis_tdata[19:13];
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (state == S_RESP && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {3'b000, scr_q, 7'(cursor_col), 5'(cursor_row),
                       res_cell.attr, res_cell.chr};
    end
  end

  assign cursor_ok     = (32'(cursor_row) < 32'(ROWS)) && (32'(cursor_col) < 32'(COLUMNS));
  assign scroll_row_ok = !(m_axis_tvalid && m_axis_tdata[28]) ||
                         (m_axis_tdata[20:16] == 5'(ROWS - 1));
  assign copy_last     = (state == S_COPY) && (32'(cnt) == 32'(COPY_N));

  `TCW_ASSERT(a_cursor_in_screen, cursor_ok, "cursor left the screen")
  `TCW_ASSERT(a_scroll_on_last_row, scroll_row_ok, "scroll result not on last row")
  `TCW_ASSERT_NEXT(a_copy_exit, copy_last, state == S_FILL, "copy did not hand over to fill")

endmodule

`default_nettype wire

// ----- tb/text_console_writer_unit_tb.sv -----
// testbench for the text console writer: random and directed put/read requests with a
// screen and cursor predictor updated per accepted request, results checked field by field
// depends on tcw_pkg and text_console_writer_unit
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int LIMIT     = 3_000_000;
  localparam int HOLD_LEN  = 600;
  localparam int PHASE_LEN = 450;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [4:0] row;
    logic [6:0] col;
  } console_req_t;

  // same bit order as m_axis_tdata[28:0]
  typedef struct packed {
    logic       scrolled;
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] attr;
    logic [7:0] chr;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // char_code[7:0], read_row[12:8], read_col[19:13]
  logic        s_axis_tuser = 1'b0; // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cell_char[7:0], cell_attr[15:8],
                                    // cursor_row[20:16], cursor_col[27:21], scrolled[28]

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted console state
  cell_t      screen_m [ROWS][COLUMNS];
  int         row_m;
  int         col_m;
  logic [7:0] attr_m;

  console_req_t    pending_reqs[$];
  console_result_t expected_results[$];
  int              reqs_pushed = 0;
  int              reqs_taken = 0;
  int              errors = 0;
  int              cycles = 0;
  int              idle_pct = 26;
  int              hold_requests = 0;
  int              hold_served = 0;
  int              hold_left = 0;
  logic            req_taken = 1'b0;

  task automatic console_step(input logic kind, input logic [23:0] data);
    logic [7:0]      code;
    logic [4:0]      rrow;
    logic [6:0]      rcol;
    console_result_t r;
    code = data[7:0];
    rrow = data[12:8];
    rcol = data[19:13];
    r = '0;
    if (kind == REQ_READ) begin
      if (rrow < ROWS && rcol < COLUMNS) begin
        r.chr  = screen_m[rrow][rcol].chr;
        r.attr = screen_m[rrow][rcol].attr;
      end
    end else begin
      if (code == NEWLINE_CODE) begin
        row_m++;
        col_m = 0;
      end else begin
        screen_m[row_m][col_m] = {attr_m, code};
        col_m++;
      end
      if (col_m >= COLUMNS) begin
        col_m = 0;
        row_m++;
      end
      if (row_m >= ROWS) begin
        for (int y = 0; y < ROWS - 1; y++)
          screen_m[y] = screen_m[y + 1];
        for (int x = 0; x < COLUMNS; x++)
          screen_m[ROWS - 1][x] = {attr_m, SPACE_CODE};
        row_m = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.row = row_m[4:0];
    r.col = col_m[6:0];
    expected_results.push_back(r);
  endtask

  task automatic compare_result(input console_result_t exp_r, input console_result_t got);
    if (got.chr !== exp_r.chr) begin
      $display("%0t: cell_char expected %0d got %0d", $time, exp_r.chr, got.chr);
      errors++;
    end
    if (got.attr !== exp_r.attr) begin
      $display("%0t: cell_attr expected %0d got %0d", $time, exp_r.attr, got.attr);
      errors++;
    end
    if (got.row !== exp_r.row) begin
      $display("%0t: cursor_row expected %0d got %0d", $time, exp_r.row, got.row);
      errors++;
    end
    if (got.col !== exp_r.col) begin
      $display("%0t: cursor_col expected %0d got %0d", $time, exp_r.col, got.col);
      errors++;
    end
    if (got.scrolled !== exp_r.scrolled) begin
      $display("%0t: scrolled expected %0d got %0d", $time, exp_r.scrolled, got.scrolled);
      errors++;
    end
  endtask

  // monitor: check results before predicting, a request never answers on its own edge
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        compare_result(expected_results.pop_front(), console_result_t'(m_axis_tdata[28:0]));
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      console_step(s_axis_tuser, s_axis_tdata);
      reqs_taken++;
    end
  end

  // request driver
  always @(negedge clk) begin
    console_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        s_axis_tdata  <= {4'b0, r.col, r.row, r.code};
        s_axis_tuser  <= r.kind;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served   <= hold_served + 1;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic push_req(input logic kind, input logic [7:0] code,
                          input logic [4:0] row, input logic [6:0] col);
    pending_reqs.push_back('{kind: kind, code: code, row: row, col: col});
    reqs_pushed++;
  endtask

  task automatic push_random(input int count);
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] code;
    int         pick;
    for (int i = 0; i < count; i++) begin
      row  = 5'($urandom_range(0, 31));
      col  = 7'($urandom_range(0, 127));
      code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // mostly on-screen reads, some anywhere in the field range
        if ($urandom_range(0, 9) != 0) begin
          row = 5'($urandom_range(0, ROWS - 1));
          col = 7'($urandom_range(0, COLUMNS - 1));
        end
        push_req(REQ_READ, code, row, col);
      end else if (pick < 45) begin
        push_req(REQ_PUT, NEWLINE_CODE, row, col);
      end else begin
        push_req(REQ_PUT, code, row, col);
      end
    end
  endtask

  task automatic wait_idle();
    while (reqs_taken != reqs_pushed || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_text_attr(input logic [7:0] value);
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    attr_m = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    for (int y = 0; y < ROWS; y++)
      for (int x = 0; x < COLUMNS; x++)
        screen_m[y][x] = '0;
    row_m  = 0;
    col_m  = 0;
    attr_m = ATTR_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: cleared store, field extremes, off-screen reads, puts at reset attribute
    push_req(REQ_READ, 8'h00, 5'd0, 7'd0);
    push_req(REQ_READ, 8'hFF, 5'd24, 7'd79);
    push_req(REQ_READ, 8'h00, 5'd25, 7'd0);
    push_req(REQ_READ, 8'h00, 5'd0, 7'd80);
    push_req(REQ_READ, 8'hFF, 5'd31, 7'd127);
    push_req(REQ_PUT, 8'h41, 5'd31, 7'd127);
    push_req(REQ_PUT, 8'h00, 5'd0, 7'd0);
    push_req(REQ_PUT, 8'hFF, 5'd0, 7'd0);
    push_req(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    push_req(REQ_PUT, 8'hF5, 5'd0, 7'd0);
    push_req(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    push_req(REQ_READ, 8'h00, 5'd0, 7'd0);
    push_req(REQ_READ, 8'h00, 5'd0, 7'd1);
    push_req(REQ_READ, 8'h00, 5'd0, 7'd2);
    push_req(REQ_READ, 8'h00, 5'd1, 7'd0);
    push_req(REQ_READ, 8'h00, 5'd1, 7'd1);
    push_req(REQ_READ, 8'h00, 5'd2, 7'd0);
    wait_idle();

    write_text_attr(8'hFF);
    push_random(PHASE_LEN);
    wait_idle();

    // stretch with no idling on either side
    write_text_attr(8'h00);
    idle_pct = 0;
    push_random(PHASE_LEN);
    wait_idle();
    idle_pct = 26;

    // receiver holds off while requests keep coming, then the sender pauses mid-phase
    write_text_attr(8'($urandom_range(1, 254)));
    push_random(PHASE_LEN / 2);
    hold_requests++;
    wait_idle();
    push_random(PHASE_LEN / 2);
    wait_idle();

    write_text_attr(8'($urandom_range(0, 255)));
    push_random(PHASE_LEN);
    wait_idle();
    repeat (10) @(negedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
